[design/ale_pkg.sv]
// Shared types, constants and echo-sequence tables for the ANSI line editor.
// No dependencies; imported by ale_front, ale_back and ansi_line_editor.
package ale_pkg;

  localparam int LEN_W        = 5;
  localparam int CAP_W        = 6;
  localparam int MAX_LINE_DEF = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int SEQ_MAX      = 7;
  localparam int SEQ_W        = 8 * SEQ_MAX;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  typedef enum logic [2:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_DELETE = 3'd2,
    OP_BKSP   = 3'd3,
    OP_INSERT = 3'd4,
    OP_ENTER  = 3'd5
  } cmd_op_e;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [7:0]       ch;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } res_t;

  // Fixed bytes sent before (suf = 0) or after (suf = 1) the line tail.
  function automatic logic [2:0] seq_len(cmd_op_e op, logic suf);
    logic [2:0] n;
    n = '0;
    if (!suf) begin
      case (op) inside
        OP_DELETE, OP_INSERT: n = 3'd3;
        OP_BKSP:              n = 3'd7;
        OP_ENTER:             n = 3'd2;
        default:              n = 3'd0;
      endcase
    end else begin
      case (op) inside
        OP_LEFT, OP_RIGHT:  n = 3'd4;
        OP_DELETE, OP_BKSP: n = 3'd4;
        OP_INSERT:          n = 3'd7;
        OP_ENTER:           n = 3'd1;
        default:            n = 3'd0;
      endcase
    end
    return n;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_str(cmd_op_e op, logic suf);
    logic [SEQ_W-1:0] s;
    s = '0;
    if (!suf) begin
      case (op) inside
        OP_DELETE, OP_INSERT: s = {CH_ESC, CH_LBR, CH_S, 32'h0};
        OP_BKSP:  s = {CH_ESC, CH_LBR, CH_ONE, CH_D, CH_ESC, CH_LBR, CH_S};
        OP_ENTER: s = {CH_CR, CH_LF, 40'h0};
        default:  s = '0;
      endcase
    end else begin
      case (op) inside
        OP_LEFT:            s = {CH_ESC, CH_LBR, CH_ONE, CH_D, 24'h0};
        OP_RIGHT:           s = {CH_ESC, CH_LBR, CH_ONE, CH_C, 24'h0};
        OP_DELETE, OP_BKSP: s = {CH_SP, CH_ESC, CH_LBR, CH_U, 24'h0};
        OP_INSERT: s = {CH_ESC, CH_LBR, CH_U, CH_ESC, CH_LBR, CH_ONE, CH_C};
        OP_ENTER:  s = {CH_NUL, 48'h0};
        default:   s = '0;
      endcase
    end
    return s;
  endfunction

  function automatic logic [7:0] seq_byte(logic [SEQ_W-1:0] s, logic [2:0] idx);
    int sh;
    sh = 8 * (SEQ_MAX - 1 - int'(idx));
    return s[sh +: 8];
  endfunction

endpackage

[design/ale_ram.sv]
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module ale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/ale_fifo.sv]
// Small register FIFO used for the command queue and the result queue.
// No dependencies.
module ale_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("fifo fill count beyond depth");

endmodule

[design/ale_front.sv]
// Front end: parses received bytes, tracks escape phase, length and cursor,
// and issues edit commands. Depends on ale_pkg.
module ale_front #(
  parameter int MAX_LINE = ale_pkg::MAX_LINE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [7:0]               rx_byte_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ale_pkg::CAP_W-1:0] cfg_data_i,
  input  logic                     cmd_full_i,
  output logic                     cmd_push_o,
  output ale_pkg::cmd_t            cmd_o
);

  import ale_pkg::*;

  localparam int LimMax = (MAX_LINE - 1 < 31) ? MAX_LINE - 1 : 31;

  typedef enum logic [3:0] {
    ESC_NONE = 4'b0001,
    ESC_SEEN = 4'b0010,
    ESC_CSI  = 4'b0100,
    ESC_CSI3 = 4'b1000
  } esc_e;

  esc_e             esc_q, esc_d;
  logic [LEN_W-1:0] len_q, len_d, cur_q, cur_d;
  logic [CAP_W-1:0] cap_q, cap_m1, limit;
  logic             accept, issue;
  logic [7:0]       c;

  assign full_o      = cmd_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !cmd_full_i;
  assign c           = rx_byte_i;

  always_comb begin
    cap_m1 = (cap_q == '0) ? '0 : cap_q - CAP_W'(1);
    limit  = (cap_m1 > CAP_W'(LimMax)) ? CAP_W'(LimMax) : cap_m1;
  end

  always_comb begin
    esc_d     = esc_q;
    len_d     = len_q;
    cur_d     = cur_q;
    issue     = 1'b0;
    cmd_o.op  = OP_LEFT;
    cmd_o.ch  = c;
    cmd_o.pos = cur_q;
    cmd_o.len = len_q;
    unique case (esc_q)
      ESC_SEEN: begin
        esc_d = (c == CH_LBR) ? ESC_CSI : ESC_NONE;
      end
      ESC_CSI: begin
        esc_d = ESC_NONE;
        if (c == CH_D && cur_q != '0) begin
          issue    = 1'b1;
          cmd_o.op = OP_LEFT;
          cur_d    = cur_q - LEN_W'(1);
        end else if (c == CH_C && cur_q < len_q) begin
          issue    = 1'b1;
          cmd_o.op = OP_RIGHT;
          cur_d    = cur_q + LEN_W'(1);
        end else if (c == CH_THREE) begin
          esc_d = ESC_CSI3;
        end
      end
      ESC_CSI3: begin
        esc_d = ESC_NONE;
        if (c == CH_TILDE && cur_q < len_q) begin
          issue    = 1'b1;
          cmd_o.op = OP_DELETE;
          len_d    = len_q - LEN_W'(1);
        end
      end
      ESC_NONE: begin
        if (c == CH_ESC) begin
          esc_d = ESC_SEEN;
        end else if (c == CH_BS || c == CH_DEL) begin
          if (cur_q != '0) begin
            issue     = 1'b1;
            cmd_o.op  = OP_BKSP;
            cmd_o.pos = cur_q - LEN_W'(1);
            cur_d     = cur_q - LEN_W'(1);
            len_d     = len_q - LEN_W'(1);
          end
        end else if (c == CH_CR || c == CH_LF) begin
          issue    = 1'b1;
          cmd_o.op = OP_ENTER;
          len_d    = '0;
          cur_d    = '0;
        end else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI &&
                     {1'b0, len_q} < limit) begin
          issue    = 1'b1;
          cmd_o.op = OP_INSERT;
          len_d    = len_q + LEN_W'(1);
          cur_d    = cur_q + LEN_W'(1);
        end
      end
      default: esc_d = ESC_NONE;
    endcase
  end

  assign cmd_push_o = accept && issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= ESC_NONE;
      len_q <= '0;
      cur_q <= '0;
      cap_q <= CAP_RESET;
    end else begin
      if (accept) begin
        esc_q <= esc_d;
        len_q <= len_d;
        cur_q <= cur_d;
      end
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  a_cur_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q && len_q <= LEN_W'(LimMax))
    else $error("cursor or length out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |-> !cmd_full_i)
    else $error("command issued into a full queue");

endmodule

[design/ale_back.sv]
// Back end: runs edit commands against the line RAM and produces echo, line
// and end-marker words. Depends on ale_pkg and ale_ram.
module ale_back #(
  parameter int MAX_LINE = ale_pkg::MAX_LINE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ale_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output ale_pkg::res_t res_o,
  output logic          res_push_o,
  input  logic          res_full_i
);

  import ale_pkg::*;

  localparam int IDX_W = $clog2(MAX_LINE);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PRE   = 5'b00010,
    S_FETCH = 5'b00100,
    S_TAIL  = 5'b01000,
    S_SUF   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  cmd_op_e          op_q, op_d;
  logic [7:0]       ch_q, ch_d;
  logic [LEN_W-1:0] ptr_q, ptr_d, end_q, end_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             skip_q, skip_d, fetch_q, fetch_d, first_q, first_d;

  logic [LEN_W-1:0] ld_start, ld_end;
  logic             ld_skip, ld_fetch, fire;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [7:0]       wdata, rd_data, tail_byte;
  logic [2:0]       pre_n, suf_n;

  function automatic state_e after_pre(logic skip, logic fetch);
    return skip ? S_SUF : (fetch ? S_FETCH : S_TAIL);
  endfunction

  always_comb begin
    ld_start = cmd_i.pos;
    ld_end   = cmd_i.len;
    ld_skip  = 1'b1;
    ld_fetch = 1'b0;
    case (cmd_i.op) inside
      OP_ENTER: begin
        ld_start = '0;
        ld_end   = cmd_i.len - LEN_W'(1);
        ld_skip  = (cmd_i.len == '0);
        ld_fetch = 1'b1;
      end
      OP_DELETE, OP_BKSP: begin
        ld_start = cmd_i.pos + LEN_W'(1);
        ld_end   = cmd_i.len - LEN_W'(1);
        ld_skip  = (cmd_i.pos + LEN_W'(1) == cmd_i.len);
        ld_fetch = 1'b1;
      end
      OP_INSERT: begin
        ld_skip  = 1'b0;
      end
      default: ld_skip = 1'b1;
    endcase
  end

  assign pre_n     = seq_len(op_q, 1'b0);
  assign suf_n     = seq_len(op_q, 1'b1);
  assign tail_byte = (op_q == OP_INSERT && first_q) ? ch_q : rd_data;
  assign fire      = res_push_o && !res_full_i;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ch_d       = ch_q;
    ptr_d      = ptr_q;
    end_d      = end_q;
    cnt_d      = cnt_q;
    skip_d     = skip_q;
    fetch_d    = fetch_q;
    first_d    = first_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.data = tail_byte;
    res_o.kind = KIND_ECHO;
    res_o.last = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = IDX_W'(ptr_q);
    wdata      = tail_byte;
    raddr      = IDX_W'(ptr_q + LEN_W'(1));
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          ch_d      = cmd_i.ch;
          ptr_d     = ld_start;
          end_d     = ld_end;
          skip_d    = ld_skip;
          fetch_d   = ld_fetch;
          first_d   = 1'b1;
          cnt_d     = '0;
          state_d   = (seq_len(cmd_i.op, 1'b0) != '0) ? S_PRE
                                                      : after_pre(ld_skip, ld_fetch);
        end
      end
      S_PRE: begin
        res_push_o = 1'b1;
        res_o.data = seq_byte(seq_str(op_q, 1'b0), cnt_q);
        if (fire) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == pre_n - 3'd1) begin
            cnt_d   = '0;
            state_d = after_pre(skip_q, fetch_q);
          end
        end
      end
      S_FETCH: begin
        re      = 1'b1;
        raddr   = IDX_W'(ptr_q);
        state_d = S_TAIL;
      end
      S_TAIL: begin
        res_push_o = 1'b1;
        res_o.data = tail_byte;
        res_o.kind = (op_q == OP_ENTER) ? KIND_LINE : KIND_ECHO;
        if (fire) begin
          re      = 1'b1;
          first_d = 1'b0;
          ptr_d   = ptr_q + LEN_W'(1);
          case (op_q) inside
            OP_INSERT: begin
              we    = 1'b1;
              raddr = IDX_W'(ptr_q);
            end
            OP_DELETE, OP_BKSP: begin
              we    = 1'b1;
              waddr = IDX_W'(ptr_q - LEN_W'(1));
              wdata = rd_data;
            end
            default: we = 1'b0;
          endcase
          if (ptr_q == end_q) begin
            cnt_d   = '0;
            state_d = S_SUF;
          end
        end
      end
      S_SUF: begin
        res_push_o = 1'b1;
        res_o.data = seq_byte(seq_str(op_q, 1'b1), cnt_q);
        res_o.kind = (op_q == OP_ENTER) ? KIND_END : KIND_ECHO;
        res_o.last = (cnt_q == suf_n - 3'd1);
        if (fire) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == suf_n - 3'd1) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    ch_q    <= ch_d;
    ptr_q   <= ptr_d;
    end_q   <= end_d;
    skip_q  <= skip_d;
    fetch_q <= fetch_d;
    first_q <= first_d;
  end

  ale_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LINE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAIL |-> ptr_q <= end_q)
    else $error("tail pointer past end of pass");

  a_write_in_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_TAIL && fire))
    else $error("line RAM written outside a tail step");

endmodule

[design/ansi_line_editor.sv]
// Terminal line editor: takes received bytes, keeps an editable line with
// cursor, and gives out echo bytes, finished lines and end markers.
// Usage:
//   Input queue: drive rx_byte_i and push; a word is taken when push is
//   high and full is low. Output queue: while empty is low the oldest
//   result sits on out_byte_o, out_kind_o, last_o; pop takes it.
//   out_kind_o: 0 echo, 1 finished line character, 2 line end marker;
//   last_o marks the final word caused by one input byte.
//   Config: cfg_data_i is the line capacity including the terminator,
//   written when cfg_valid_i and cfg_ready_o are high (ready is always high).
// Timing:
//   A taken byte's command is written into the command queue; the back end
//   loads it, then sends one word a cycle while the result queue has room:
//   the fixed prefix, a RAM prefetch step for enter, delete and backspace
//   where the first tail byte is read, the tail and the fixed suffix.
//   Escape and dropped bytes issue no command.
//   A two-entry command queue lets input run ahead of the back end.
// Reset clears the line, cursor and escape phase and sets capacity to 32;
// line RAM contents need no clearing. When the receiver stops popping, the
// back end holds its place and the command queue then fills and raises full.
module ansi_line_editor #(
  parameter int MAX_LINE = ale_pkg::MAX_LINE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                rx_byte_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                out_byte_o,
  output logic [1:0]                out_kind_o,
  output logic                      last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ale_pkg::CAP_W-1:0] cfg_data_i
);

  import ale_pkg::*;

  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic res_push, res_full;

  ale_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  ale_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  ale_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  ale_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign out_byte_o = res_out.data;
  assign out_kind_o = res_out.kind;
  assign last_o     = res_out.last;

endmodule
